// File: design/http_header_line_parser_defines.svh
// ----------------------------------------------------------------------------
// http_header_line_parser_defines.svh
// Assertion macros shared by the header line parser RTL.
// ----------------------------------------------------------------------------
`ifndef HTTP_HEADER_LINE_PARSER_DEFINES_SVH
`define HTTP_HEADER_LINE_PARSER_DEFINES_SVH

// Checked on every clock edge outside reset.
`define HHLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define HHLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/hhlp_pkg.sv
// ----------------------------------------------------------------------------
// hhlp_pkg
// Types and constants of the HTTP header line parser.
// ----------------------------------------------------------------------------
package hhlp_pkg;

    localparam int unsigned MAX_W    = 10;
    localparam int unsigned OFFSET_W = 11;

    localparam logic [MAX_W-1:0] MAX_RESET = 10'd255;

    // byte kinds
    localparam logic [3:0] KIND_SKIP  = 4'd0;
    localparam logic [3:0] KIND_KEY   = 4'd1;
    localparam logic [3:0] KIND_COLON = 4'd2;
    localparam logic [3:0] KIND_SPACE = 4'd3;
    localparam logic [3:0] KIND_VALUE = 4'd4;
    localparam logic [3:0] KIND_VCR   = 4'd5;
    localparam logic [3:0] KIND_LF    = 4'd6;
    localparam logic [3:0] KIND_BCR   = 4'd7;
    localparam logic [3:0] KIND_END   = 4'd8;
    localparam logic [3:0] KIND_ERR   = 4'd9;

    // error causes
    localparam logic [2:0] CAUSE_NONE     = 3'd0;
    localparam logic [2:0] CAUSE_KEY_EOL  = 3'd1;
    localparam logic [2:0] CAUSE_NO_SPACE = 3'd2;
    localparam logic [2:0] CAUSE_TOO_LONG = 3'd3;
    localparam logic [2:0] CAUSE_NO_LF    = 3'd4;
    localparam logic [2:0] CAUSE_END_NOLF = 3'd5;

    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;

    typedef enum logic [7:0] {
        PH_START    = 8'b0000_0001,
        PH_KEY      = 8'b0000_0010,
        PH_COLON    = 8'b0000_0100,
        PH_SPACE    = 8'b0000_1000,
        PH_VALUE    = 8'b0001_0000,
        PH_VALUE_CR = 8'b0010_0000,
        PH_LINE_LF  = 8'b0100_0000,
        PH_BLANK_CR = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [2:0] cause;
    } result_t;

endpackage

// File: design/hhlp_if.sv
// ----------------------------------------------------------------------------
// hhlp_byte_if / hhlp_result_if
// Valid/ready channels for header bytes in and tagged bytes out.
// ----------------------------------------------------------------------------
interface hhlp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

interface hhlp_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_echo;
    logic [3:0] byte_kind;
    logic [2:0] error_cause;

    modport source (output valid, output byte_echo, output byte_kind, output error_cause,
                    input ready);
    modport sink   (input valid, input byte_echo, input byte_kind, input error_cause,
                    output ready);
endinterface

// File: design/hhlp_classifier.sv
// ----------------------------------------------------------------------------
// hhlp_classifier
// Parser state machine: tags one byte per step and tracks the value offset.
// ----------------------------------------------------------------------------
module hhlp_classifier
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [7:0]                     data_byte,
    input  logic [hhlp_pkg::MAX_W-1:0]     max_value_offset,
    output hhlp_pkg::result_t              res
);

    hhlp_pkg::phase_t                  phase_reg;
    hhlp_pkg::phase_t                  phase_next;
    logic [hhlp_pkg::OFFSET_W-1:0]     offset_reg;
    logic [hhlp_pkg::OFFSET_W-1:0]     offset_next;
    logic [hhlp_pkg::OFFSET_W-1:0]     offset_inc;
    logic                              too_long;
    logic                              is_cr;
    logic                              is_lf;

    assign is_cr      = (data_byte == hhlp_pkg::CH_CR);
    assign is_lf      = (data_byte == hhlp_pkg::CH_LF);
    assign offset_inc = offset_reg + 11'd1;
    assign too_long   = (offset_inc > {1'b0, max_value_offset});

    always_comb
    begin
        res.kind    = hhlp_pkg::KIND_KEY;
        res.cause   = hhlp_pkg::CAUSE_NONE;
        phase_next  = phase_reg;
        offset_next = offset_reg;
        case (phase_reg)
            hhlp_pkg::PH_KEY:
            begin
                if (data_byte == hhlp_pkg::CH_COLON)
                begin
                    res.kind   = hhlp_pkg::KIND_COLON;
                    phase_next = hhlp_pkg::PH_COLON;
                end
                else if (is_cr || is_lf)
                begin
                    res.kind  = hhlp_pkg::KIND_ERR;
                    res.cause = hhlp_pkg::CAUSE_KEY_EOL;
                end
                else
                begin
                    res.kind = hhlp_pkg::KIND_KEY;
                end
            end
            hhlp_pkg::PH_COLON:
            begin
                if (data_byte == hhlp_pkg::CH_SP)
                begin
                    res.kind   = hhlp_pkg::KIND_SPACE;
                    phase_next = hhlp_pkg::PH_SPACE;
                end
                else
                begin
                    res.kind  = hhlp_pkg::KIND_ERR;
                    res.cause = hhlp_pkg::CAUSE_NO_SPACE;
                end
            end
            hhlp_pkg::PH_SPACE:
            begin
                // first value byte is taken whatever it is
                res.kind    = hhlp_pkg::KIND_VALUE;
                offset_next = '0;
                phase_next  = hhlp_pkg::PH_VALUE;
            end
            hhlp_pkg::PH_VALUE:
            begin
                if (is_cr)
                begin
                    res.kind   = hhlp_pkg::KIND_VCR;
                    phase_next = hhlp_pkg::PH_VALUE_CR;
                end
                else if (too_long)
                begin
                    res.kind  = hhlp_pkg::KIND_ERR;
                    res.cause = hhlp_pkg::CAUSE_TOO_LONG;
                end
                else
                begin
                    res.kind    = hhlp_pkg::KIND_VALUE;
                    offset_next = offset_inc;
                end
            end
            hhlp_pkg::PH_VALUE_CR:
            begin
                if (is_lf)
                begin
                    res.kind   = hhlp_pkg::KIND_LF;
                    phase_next = hhlp_pkg::PH_LINE_LF;
                end
                else
                begin
                    res.kind  = hhlp_pkg::KIND_ERR;
                    res.cause = hhlp_pkg::CAUSE_NO_LF;
                end
            end
            hhlp_pkg::PH_LINE_LF:
            begin
                if (is_cr)
                begin
                    res.kind   = hhlp_pkg::KIND_BCR;
                    phase_next = hhlp_pkg::PH_BLANK_CR;
                end
                else
                begin
                    res.kind   = hhlp_pkg::KIND_KEY;
                    phase_next = hhlp_pkg::PH_KEY;
                end
            end
            hhlp_pkg::PH_BLANK_CR:
            begin
                if (is_lf)
                begin
                    res.kind    = hhlp_pkg::KIND_END;
                    phase_next  = hhlp_pkg::PH_START;
                    offset_next = '0;
                end
                else
                begin
                    res.kind  = hhlp_pkg::KIND_ERR;
                    res.cause = hhlp_pkg::CAUSE_END_NOLF;
                end
            end
            default:
            begin
                // start: leading line breaks are skipped
                if (is_cr || is_lf)
                begin
                    res.kind   = hhlp_pkg::KIND_SKIP;
                    phase_next = hhlp_pkg::PH_START;
                end
                else
                begin
                    res.kind   = hhlp_pkg::KIND_KEY;
                    phase_next = hhlp_pkg::PH_KEY;
                end
            end
        endcase

        if (res.kind == hhlp_pkg::KIND_ERR)
        begin
            phase_next  = hhlp_pkg::PH_START;
            offset_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= hhlp_pkg::PH_START;
            offset_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            offset_reg <= offset_next;
        end
    end

endmodule

// File: design/http_header_line_parser.sv
// ----------------------------------------------------------------------------
// http_header_line_parser
// Tags each byte of an HTTP header section (key, colon, space, value,
// line breaks, block end) or flags it as an error with a cause.
// Pipeline: an accepted byte is held in the input reg, then in the result reg with its tag.
// Throughput: 1 byte per cycle while result_out.ready holds; the phase/offset update is registered with the result.
// Reset: phase to start, value offset to 0, both stages empty, limit to 255.
// ----------------------------------------------------------------------------
`include "http_header_line_parser_defines.svh"

module http_header_line_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    hhlp_byte_if.sink                  byte_in,
    hhlp_result_if.source              result_out,
    input  logic                       cfg_we,
    input  logic [hhlp_pkg::MAX_W-1:0] cfg_wdata
);

    logic [hhlp_pkg::MAX_W-1:0] max_value_offset_reg;

    logic                       s1_valid_reg;
    logic [7:0]                 s1_byte_reg;

    logic                       out_valid_reg;
    logic [7:0]                 out_byte_reg;
    hhlp_pkg::result_t          out_res_reg;

    hhlp_pkg::result_t          res;
    logic                       out_free;
    logic                       advance;
    logic                       in_fire;

    logic                       out_err;
    logic                       out_has_cause;
    logic                       out_end;

    assign out_free      = !out_valid_reg || result_out.ready;
    assign advance       = s1_valid_reg && out_free;
    assign byte_in.ready = !s1_valid_reg || advance;
    assign in_fire       = byte_in.valid && byte_in.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_value_offset_reg <= hhlp_pkg::MAX_RESET;
        end
        else if (cfg_we)
        begin
            max_value_offset_reg <= cfg_wdata;
        end
    end

    hhlp_classifier u_classifier
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .step             (advance),
        .data_byte        (s1_byte_reg),
        .max_value_offset (max_value_offset_reg),
        .res              (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (byte_in.ready)
            begin
                s1_valid_reg <= byte_in.valid;
            end
            if (out_free)
            begin
                out_valid_reg <= advance;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_byte_reg <= byte_in.data_byte;
        end
        if (advance)
        begin
            out_byte_reg <= s1_byte_reg;
            out_res_reg  <= res;
        end
    end

    assign result_out.valid       = out_valid_reg;
    assign result_out.byte_echo   = out_byte_reg;
    assign result_out.byte_kind   = out_res_reg.kind;
    assign result_out.error_cause = out_res_reg.cause;

    assign out_err       = (out_res_reg.kind == hhlp_pkg::KIND_ERR);
    assign out_has_cause = (out_res_reg.cause != hhlp_pkg::CAUSE_NONE);
    assign out_end       = out_valid_reg && (out_res_reg.kind == hhlp_pkg::KIND_END);

    `HHLP_ASSERT(a_cause_iff_error, out_valid_reg |-> (out_err == out_has_cause), "cause mismatch")
    `HHLP_ASSERT(a_accept_fills_stage, in_fire |=> s1_valid_reg, "accepted byte lost")
    `HHLP_ASSERT(a_end_is_lf, out_end |-> (out_byte_reg == hhlp_pkg::CH_LF), "end not on LF")
    `HHLP_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> (!s1_valid_reg && !out_valid_reg), "not empty")

endmodule
